[hw/rtl/abst_pkg.sv]
package abst_pkg;

   // Width of the result slot field; larger indices are masked to it.
   localparam int SLOT_W = 10;
   // Widest tree the design supports, used to widen indices before masking.
   localparam int LEVELS_MAX = 16;
   // Width of one stored key.
   localparam int KEY_W = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } abst_op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_PATH_FULL = 2'd2,
      STAT_ZERO      = 2'd3
   } abst_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } abst_state_type;

   // Port enables of the node memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } abst_mem_ctl_type;

   // Finished result handed from the sequencer to the output register.
   typedef struct packed {
      abst_status_type   status;
      logic [SLOT_W-1:0] slot;
   } abst_result_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic clearing;
      logic res_valid;
   } abst_stat_type;

endpackage

[hw/rtl/abst_mem.sv]
module abst_mem import abst_pkg::*; #(
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  abst_mem_ctl_type  mem_ctl,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [KEY_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [KEY_W-1:0]  rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [KEY_W-1:0] mem_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Single read port with registered data; the data holds between reads.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/abst_ctrl.sv]
module abst_ctrl import abst_pkg::*; #(
   parameter int LEVELS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [KEY_W-1:0]  req_value,
   input  logic              out_free,
   output abst_result_type   result,
   output abst_stat_type     stat,
   output abst_mem_ctl_type  mem_ctl,
   output logic [LEVELS-1:0] wr_addr,
   output logic [KEY_W-1:0]  wr_data,
   output logic [LEVELS-1:0] rd_addr,
   input  logic [KEY_W-1:0]  rd_data
);

   abst_state_type    state_ff, state_in;
   abst_op_type       op_ff, op_in;
   logic [KEY_W-1:0]  value_ff, value_in;
   logic [LEVELS-1:0] idx_ff, idx_in;
   logic [LEVELS-1:0] clr_ff, clr_in;
   abst_result_type   result_ff, result_in;

   logic                  accept;
   logic                  here_empty;
   logic                  here_equal;
   logic                  go_right;
   logic                  at_last;
   logic [LEVELS-1:0]     next_idx;
   logic [LEVELS_MAX-1:0] idx_wide;
   logic [SLOT_W-1:0]     idx_slot;

   // State register and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Payload registers of the request under way.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      result_ff <= result_in;
   end

   // Compare of the node just read against the key.
   assign here_empty = (rd_data == '0);
   assign here_equal = (rd_data == value_ff);
   assign go_right   = ($signed(value_ff) > $signed(rd_data));
   assign at_last    = idx_ff[LEVELS-1];
   assign next_idx   = {idx_ff[LEVELS-2:0], go_right};

   // Slot index widened to the largest tree and then masked to the field.
   assign idx_wide = LEVELS_MAX'(idx_ff);
   assign idx_slot = idx_wide[SLOT_W-1:0];

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Next state, memory accesses and the result.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      value_in  = value_ff;
      idx_in    = idx_ff;
      clr_in    = clr_ff;
      result_in = result_ff;
      mem_ctl   = '0;
      rd_addr   = LEVELS'(1);
      wr_addr   = idx_ff;
      wr_data   = value_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the memory once after reset, one entry a cycle.
            mem_ctl.wr_en = 1'b1;
            wr_addr       = clr_ff;
            wr_data       = '0;
            clr_in        = clr_ff + LEVELS'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Take a request and read the root right away.
            if (accept) begin
               op_in         = abst_op_type'(req_operation);
               value_in      = req_value;
               idx_in        = LEVELS'(1);
               mem_ctl.rd_en = 1'b1;
               rd_addr       = LEVELS'(1);
               if (req_value == '0) begin
                  result_in = '{status: STAT_ZERO, slot: '0};
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // One tree level per cycle: decide, or read the chosen child.
            rd_addr = next_idx;
            if (op_ff == OP_INSERT) begin
               if (here_empty) begin
                  mem_ctl.wr_en = 1'b1;
                  result_in     = '{status: STAT_OK, slot: idx_slot};
                  state_in      = ST_DONE;
               end else if (at_last) begin
                  result_in = '{status: STAT_PATH_FULL, slot: '0};
                  state_in  = ST_DONE;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  idx_in        = next_idx;
               end
            end else begin
               if (here_empty) begin
                  result_in = '{status: STAT_NOT_FOUND, slot: '0};
                  state_in  = ST_DONE;
               end else if (here_equal) begin
                  result_in = '{status: STAT_OK, slot: idx_slot};
                  state_in  = ST_DONE;
               end else if (at_last) begin
                  result_in = '{status: STAT_NOT_FOUND, slot: '0};
                  state_in  = ST_DONE;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  idx_in        = next_idx;
               end
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register has room.
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign result         = result_ff;
   assign stat.clearing  = (state_ff == ST_CLEAR);
   assign stat.res_valid = (state_ff == ST_DONE);

endmodule

[hw/rtl/array_bst_insert_search.sv]
// Channel  | Direction | Signals
// request  | in        | req_valid, req_stall, req_operation, req_value
// response | out       | rsp_valid, rsp_stall, rsp_status, rsp_slot_index
//
// A request visits n tree levels (1 to TREE_LEVELS); the single read port of the node
// memory serves one level a cycle.
// A zero key is answered without walking the tree.
// After reset all 2^TREE_LEVELS memory entries are cleared while req_stall is high.
// A result waits in the output register under rsp_stall while the next request walks.
module array_bst_insert_search import abst_pkg::*; #(
   parameter int TREE_LEVELS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [KEY_W-1:0]  req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot_index
);

   abst_mem_ctl_type       mem_ctl;
   logic [TREE_LEVELS-1:0] wr_addr;
   logic [KEY_W-1:0]       wr_data;
   logic [TREE_LEVELS-1:0] rd_addr;
   logic [KEY_W-1:0]       rd_data;
   abst_result_type        result;
   abst_stat_type          stat;
   logic                   out_free;
   logic                   res_taken;

   logic              rsp_valid_ff, rsp_valid_in;
   abst_result_type   rsp_data_ff, rsp_data_in;

   abst_ctrl #(
      .LEVELS (TREE_LEVELS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .out_free      (out_free),
      .result        (result),
      .stat          (stat),
      .mem_ctl       (mem_ctl),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   abst_mem #(
      .ADDR_W (TREE_LEVELS)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The output register has room when empty or being emptied this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign res_taken = stat.res_valid && out_free;

   // Output register next value.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_slot_index = rsp_data_ff.slot;

   // No request is taken while the memory is being cleared.
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> req_stall)
      else $error("request accepted during memory clear");

   // A result handed over appears at the output in the next cycle.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      res_taken |=> rsp_valid)
      else $error("result handed over but not presented");

   // Any status other than success carries slot zero.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_slot_index == '0))
      else $error("nonzero slot with failing status");

   // The memory is never written when a request is accepted and the read of its root starts.
   a_no_wr_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !mem_ctl.wr_en)
      else $error("memory write at request accept");

endmodule
